// ===== hw/rtl/bba_pkg.sv =====
// Shared widths, codes and helpers of the buddy allocator.
`default_nettype none

package bba_pkg;

    localparam int ORDER_W = 5;
    localparam int BYTES_W = 20;
    localparam int ADDR_W = 16;
    localparam int STATUS_W = 2;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam int POOL_ORDER_DEF = 16;
    localparam int LEAST_ORDER_DEF = 4;

    localparam logic [ORDER_W-1:0] MIN_ORDER_RST = 5'd4;
    localparam logic [ORDER_W-1:0] MAX_ORDER_RST = 5'd16;

    // Register select, taken from paddr[2]
    localparam logic CFG_MIN_ORDER = 1'b0;
    localparam logic CFG_MAX_ORDER = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_POOL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    // Smallest k with 2^k >= n; zero for n of zero or one.
    function automatic logic [ORDER_W-1:0] bytes_to_order(logic [BYTES_W-1:0] n);
        logic [BYTES_W-1:0] m;
        logic [ORDER_W-1:0] k;
        m = n - BYTES_W'(1);
        k = '0;
        if (n > BYTES_W'(1))
        begin
            for (int i = 0; i < BYTES_W; i++)
            begin
                if (m[i])
                begin
                    k = ORDER_W'(i + 1);
                end
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bba_if.sv =====
// Request and response channel interfaces of the buddy allocator.
`default_nettype none

interface bba_req_if import bba_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [BYTES_W-1:0]   request_bytes;
    logic [ADDR_W-1:0]    free_address;

    modport source (output valid, req_type, request_bytes, free_address, input ready);
    modport sink (input valid, req_type, request_bytes, free_address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    block_address;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, block_address, status, input ready);
    modport sink (input valid, block_address, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// Single write port, single registered read port memory.
`default_nettype none

module bba_ram #(
    parameter int AW = 7,
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// Top level of the binary buddy allocator: sequencer, free counts and config port.
`default_nettype none

// Channel   Dir  Handshake            Payload
// req       in   valid/ready          req_type, request_bytes, free_address
// rsp       out  valid/ready          block_address, status
// apb       in   psel/penable/pready  paddr, pwdata, prdata (min_order, max_order)
//
// Steps: an allocate runs A_ORDER, A_FIND, then a scan step per word and a split step
//   per level; a free runs F_CHECK, F_LOOK, then a merge step per level merged plus one.
//   The free-map port is the limit: each such step is one read then one check/write.
// Reset, and any config write, start a clearing pass over every address of both
//   memories, during which req is not ready.
// A finished response waits in the output register; the next request is accepted
//   meanwhile and holds in its final state until that register frees.

module buddy_block_allocator_core import bba_pkg::*; #(
    parameter int POOL_ORDER = POOL_ORDER_DEF,
    parameter int LEAST_ORDER = LEAST_ORDER_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    bba_req_if.sink                req,
    bba_rsp_if.source              rsp
);

    // Free map geometry: node n of order o is 2^(P-o) + (a >> o), packed W bits a word.
    localparam int NODE_BITS = POOL_ORDER - LEAST_ORDER + 1;
    localparam int WL_RAW = (NODE_BITS - 1 > 6) ? 6 : NODE_BITS - 1;
    localparam int WL = (WL_RAW < 1) ? 1 : WL_RAW;
    localparam int W = 2 ** WL;
    localparam int NB = (NODE_BITS > WL) ? NODE_BITS : WL + 1;
    localparam int FM_AW = NB - WL;
    localparam int LF_AW = (POOL_ORDER - LEAST_ORDER > 0) ? POOL_ORDER - LEAST_ORDER : 1;
    localparam int CLR_W = (FM_AW > LF_AW) ? FM_AW : LF_AW;
    localparam int CNT_N = POOL_ORDER - LEAST_ORDER + 1;
    localparam int CNT_W = POOL_ORDER - LEAST_ORDER + 1;
    localparam int PW = POOL_ORDER;

    localparam logic [ORDER_W-1:0] LEAST_O = ORDER_W'(LEAST_ORDER);
    localparam logic [ORDER_W-1:0] POOL_O = ORDER_W'(POOL_ORDER);

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_A_ORDER  = 14'b00000000000100,
        S_A_FIND   = 14'b00000000001000,
        S_A_RD     = 14'b00000000010000,
        S_A_CHK    = 14'b00000000100000,
        S_SPLIT_RD = 14'b00000001000000,
        S_SPLIT_WR = 14'b00000010000000,
        S_F_CHECK  = 14'b00000100000000,
        S_F_LOOK   = 14'b00001000000000,
        S_M_RD     = 14'b00010000000000,
        S_M_CHK    = 14'b00100000000000,
        S_DONE     = 14'b01000000000000,
        S_SPARE    = 14'b10000000000000
    } state_t;

    function automatic logic [NB-1:0] node_of(logic [ORDER_W-1:0] o, logic [PW-1:0] a);
        logic [31:0] t;
        t = (32'd1 << (POOL_O - o)) + (32'(a) >> o);
        return t[NB-1:0];
    endfunction

    // Bits of a word that belong to the row of order o
    function automatic logic [W-1:0] row_mask(logic [ORDER_W-1:0] o);
        int r;
        logic [W-1:0] m;
        r = POOL_ORDER - int'(o);
        m = '1;
        if (r < WL)
        begin
            for (int b = 0; b < W; b++)
            begin
                m[b] = ((b >> r) == 1);
            end
        end
        return m;
    endfunction

    function automatic logic [WL-1:0] lowest_set(logic [W-1:0] v);
        logic [WL-1:0] idx;
        idx = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = WL'(i);
            end
        end
        return idx;
    endfunction

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [ORDER_W-1:0] min_reg, min_next, max_reg, max_next;
    logic out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg [CNT_N];

    logic req_type_reg, req_type_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic [ORDER_W-1:0] k_reg, k_next, o_reg, o_next;
    logic [PW-1:0] a_reg, a_next;
    logic [FM_AW-1:0] w_reg, w_next;
    logic [NB-1:0] rs_reg, rs_next, node_reg, node_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [ORDER_W-1:0] lo_eff, hi_eff;
    logic cfg_we, in_fire;
    logic [CNT_N-1:0] nz, above_hi, cand;
    logic cnt_en, cnt_inc;
    logic [ORDER_W-1:0] cnt_o;

    logic fm_we;
    logic [FM_AW-1:0] fm_waddr, fm_raddr;
    logic [W-1:0] fm_wdata, fm_rdata;
    logic ao_we;
    logic [LF_AW-1:0] ao_waddr, ao_raddr;
    logic [ORDER_W-1:0] ao_wdata, ao_rdata;

    bba_ram #(.AW(FM_AW), .DW(W)) u_free_map (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    bba_ram #(.AW(LF_AW), .DW(ORDER_W)) u_alloc_order (
        .clk   (clk),
        .we    (ao_we),
        .waddr (ao_waddr),
        .wdata (ao_wdata),
        .raddr (ao_raddr),
        .rdata (ao_rdata)
    );

    // Effective orders: clamp min into the parameter range, max into [min, pool]
    always_comb
    begin
        lo_eff = min_reg;
        if (lo_eff < LEAST_O)
        begin
            lo_eff = LEAST_O;
        end
        if (lo_eff > POOL_O)
        begin
            lo_eff = POOL_O;
        end
        hi_eff = max_reg;
        if (hi_eff < lo_eff)
        begin
            hi_eff = lo_eff;
        end
        if (hi_eff > POOL_O)
        begin
            hi_eff = POOL_O;
        end
    end

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_MAX_ORDER) ? APB_DW'(max_reg) : APB_DW'(min_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.status = out_status_reg;

    // Per-order view of the free counts: nonempty, above the pool, candidate for the search
    always_comb
    begin
        for (int i = 0; i < CNT_N; i++)
        begin
            nz[i] = (cnt_reg[i] != '0);
            above_hi[i] = (ORDER_W'(LEAST_ORDER + i) > hi_eff);
            cand[i] = nz[i] && !above_hi[i] && (ORDER_W'(LEAST_ORDER + i) >= k_reg);
        end
    end

    always_comb
    begin
        logic [ORDER_W-1:0] k_tmp, o_tmp;
        logic [NB-1:0] n_tmp;
        logic [W-1:0] masked;
        logic [WL-1:0] bit_idx;
        logic [31:0] wide;
        logic found;

        state_next = state_reg;
        clr_idx_next = clr_idx_reg;
        min_next = min_reg;
        max_next = max_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        req_type_next = req_type_reg;
        bytes_next = bytes_reg;
        faddr_next = faddr_reg;
        k_next = k_reg;
        o_next = o_reg;
        a_next = a_reg;
        w_next = w_reg;
        rs_next = rs_reg;
        node_next = node_reg;
        st_next = st_reg;
        out_addr_next = out_addr_reg;
        out_status_next = out_status_reg;
        cnt_en = 1'b0;
        cnt_inc = 1'b0;
        cnt_o = o_reg;
        fm_we = 1'b0;
        fm_waddr = w_reg;
        fm_wdata = fm_rdata;
        fm_raddr = w_reg;
        ao_we = 1'b0;
        ao_waddr = a_reg[PW-1 -: 1] == 1'b0 ? LF_AW'(32'(a_reg) >> LEAST_ORDER)
                                               : LF_AW'(32'(a_reg) >> LEAST_ORDER);
        ao_wdata = '0;
        ao_raddr = LF_AW'(32'(faddr_reg) >> LEAST_ORDER);
        k_tmp = '0;
        o_tmp = '0;
        n_tmp = '0;
        masked = '0;
        bit_idx = '0;
        wide = '0;
        found = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep both memories; only the whole-pool node is left free
                n_tmp = node_of(hi_eff, '0);
                fm_we = 1'b1;
                fm_waddr = clr_idx_reg[FM_AW-1:0];
                fm_wdata = '0;
                if (clr_idx_reg[FM_AW-1:0] == n_tmp[NB-1:WL])
                begin
                    fm_wdata[n_tmp[WL-1:0]] = 1'b1;
                end
                ao_we = 1'b1;
                ao_waddr = clr_idx_reg[LF_AW-1:0];
                clr_idx_next = clr_idx_reg + CLR_W'(1);
                if (&clr_idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_type_next = req.req_type;
                    bytes_next = req.request_bytes;
                    faddr_next = req.free_address;
                    state_next = (req.req_type == REQ_FREE) ? S_F_CHECK : S_A_ORDER;
                end
            end
            S_A_ORDER:
            begin
                k_tmp = bytes_to_order(bytes_reg);
                if (k_tmp < lo_eff)
                begin
                    k_tmp = lo_eff;
                end
                k_next = k_tmp;
                if (k_tmp > hi_eff)
                begin
                    st_next = ST_NO_FIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_FIND;
                end
            end
            S_A_FIND:
            begin
                // Smallest order at or above k with a free block
                for (int i = CNT_N - 1; i >= 0; i--)
                begin
                    if (cand[i])
                    begin
                        o_tmp = ORDER_W'(LEAST_ORDER + i);
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    wide = 32'd1 << (POOL_O - o_tmp);
                    o_next = o_tmp;
                    rs_next = wide[NB-1:0];
                    w_next = wide[NB-1:WL];
                    state_next = S_A_RD;
                end
                else
                begin
                    st_next = ST_NO_FIT;
                    state_next = S_DONE;
                end
            end
            S_A_RD:
            begin
                fm_raddr = w_reg;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                masked = fm_rdata & row_mask(o_reg);
                if (masked != '0)
                begin
                    bit_idx = lowest_set(masked);
                    n_tmp = {w_reg, bit_idx} ^ rs_reg;
                    wide = 32'(n_tmp) << o_reg;
                    a_next = wide[PW-1:0];
                    fm_we = 1'b1;
                    fm_waddr = w_reg;
                    fm_wdata = fm_rdata;
                    fm_wdata[bit_idx] = 1'b0;
                    cnt_en = 1'b1;
                    cnt_o = o_reg;
                    st_next = ST_OK;
                    state_next = (o_reg > k_reg) ? S_SPLIT_RD : S_DONE;
                end
                else
                begin
                    w_next = w_reg + FM_AW'(1);
                    state_next = S_A_RD;
                end
            end
            S_SPLIT_RD:
            begin
                // Upper half of the block one order down becomes free
                o_tmp = o_reg - ORDER_W'(1);
                wide = 32'(a_reg) + (32'd1 << o_tmp);
                n_tmp = node_of(o_tmp, wide[PW-1:0]);
                o_next = o_tmp;
                node_next = n_tmp;
                fm_raddr = n_tmp[NB-1:WL];
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR:
            begin
                fm_we = 1'b1;
                fm_waddr = node_reg[NB-1:WL];
                fm_wdata = fm_rdata;
                fm_wdata[node_reg[WL-1:0]] = 1'b1;
                cnt_en = 1'b1;
                cnt_inc = 1'b1;
                cnt_o = o_reg;
                state_next = (o_reg > k_reg) ? S_SPLIT_RD : S_DONE;
            end
            S_F_CHECK:
            begin
                wide = 32'(faddr_reg);
                a_next = wide[PW-1:0];
                ao_raddr = LF_AW'(wide >> LEAST_ORDER);
                if ((wide >> hi_eff) != 32'd0)
                begin
                    st_next = ST_OUT_OF_POOL;
                    state_next = S_DONE;
                end
                else if ((wide & ((32'd1 << LEAST_ORDER) - 32'd1)) != 32'd0)
                begin
                    st_next = ST_NOT_ALLOC;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F_LOOK;
                end
            end
            S_F_LOOK:
            begin
                if (ao_rdata == '0)
                begin
                    st_next = ST_NOT_ALLOC;
                    state_next = S_DONE;
                end
                else
                begin
                    ao_we = 1'b1;
                    ao_waddr = LF_AW'(32'(a_reg) >> LEAST_ORDER);
                    o_tmp = ao_rdata - ORDER_W'(1);
                    if (o_tmp < LEAST_O)
                    begin
                        o_tmp = LEAST_O;
                    end
                    if (o_tmp > hi_eff)
                    begin
                        o_tmp = hi_eff;
                    end
                    o_next = o_tmp;
                    state_next = S_M_RD;
                end
            end
            S_M_RD:
            begin
                // Own node and buddy share a word: they differ only in bit zero
                n_tmp = node_of(o_reg, a_reg);
                node_next = n_tmp;
                fm_raddr = n_tmp[NB-1:WL];
                state_next = S_M_CHK;
            end
            S_M_CHK:
            begin
                fm_we = 1'b1;
                fm_waddr = node_reg[NB-1:WL];
                fm_wdata = fm_rdata;
                cnt_en = 1'b1;
                cnt_o = o_reg;
                bit_idx = node_reg[WL-1:0] ^ WL'(1);
                if ((o_reg < hi_eff) && fm_rdata[bit_idx])
                begin
                    // Buddy free: take it and climb one order
                    fm_wdata[bit_idx] = 1'b0;
                    wide = 32'(a_reg) & ~(32'd1 << o_reg);
                    a_next = wide[PW-1:0];
                    o_next = o_reg + ORDER_W'(1);
                    state_next = S_M_RD;
                end
                else
                begin
                    fm_wdata[node_reg[WL-1:0]] = 1'b1;
                    cnt_inc = 1'b1;
                    st_next = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Record the order of a fresh block; repeating the write is harmless
                if (req_type_reg == REQ_ALLOC && st_reg == ST_OK)
                begin
                    ao_we = 1'b1;
                    ao_waddr = LF_AW'(32'(a_reg) >> LEAST_ORDER);
                    ao_wdata = k_reg + ORDER_W'(1);
                end
                if (!out_valid_reg || rsp.ready)
                begin
                    wide = 32'(a_reg);
                    out_valid_next = 1'b1;
                    out_status_next = st_reg;
                    out_addr_next = (req_type_reg == REQ_ALLOC && st_reg == ST_OK) ?
                                    wide[ADDR_W-1:0] : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_idx_next = '0;
            end
        endcase

        // A register write restarts the clearing pass
        if (cfg_we)
        begin
            if (paddr[2] == CFG_MIN_ORDER)
            begin
                min_next = pwdata[ORDER_W-1:0];
            end
            else
            begin
                max_next = pwdata[ORDER_W-1:0];
            end
            state_next = S_CLEAR;
            clr_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_idx_reg <= '0;
            min_reg <= MIN_ORDER_RST;
            max_reg <= MAX_ORDER_RST;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CNT_N; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_idx_reg <= clr_idx_next;
            min_reg <= min_next;
            max_reg <= max_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CNT_N; i++)
            begin
                if (state_reg == S_CLEAR)
                begin
                    cnt_reg[i] <= (ORDER_W'(LEAST_ORDER + i) == hi_eff) ? CNT_W'(1) : '0;
                end
                else if (cnt_en && cnt_o == ORDER_W'(LEAST_ORDER + i))
                begin
                    cnt_reg[i] <= cnt_inc ? cnt_reg[i] + CNT_W'(1) : cnt_reg[i] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        bytes_reg <= bytes_next;
        faddr_reg <= faddr_next;
        k_reg <= k_next;
        o_reg <= o_next;
        a_reg <= a_next;
        w_reg <= w_next;
        rs_reg <= rs_next;
        node_reg <= node_next;
        st_reg <= st_next;
        out_addr_reg <= out_addr_next;
        out_status_reg <= out_status_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !req.ready)
        else $error("request accepted while a previous one is in progress");

    a_no_free_above_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |-> ((nz & above_hi) == '0))
        else $error("free block counted above the pool order");

    a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && req_type_reg == REQ_ALLOC && st_reg == ST_OK) |->
        ((32'(a_reg) & ((32'd1 << k_reg) - 32'd1)) == 32'd0))
        else $error("allocated block not aligned to its order");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_buddy_block_allocator_core.sv =====
// Self-checking testbench of the buddy allocator: directed and random requests, APB reconfiguration.
`timescale 1ns / 100ps

module tb_buddy_block_allocator_core;
    import bba_pkg::*;

    localparam int POOL = POOL_ORDER_DEF;
    localparam int LEAST = LEAST_ORDER_DEF;
    localparam int NODES = 1 << (POOL - LEAST + 1);
    localparam int LEAVES = 1 << (POOL - LEAST);
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_address;
        logic [STATUS_W-1:0] status;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req_ch.sink), .rsp(rsp_ch.source)
    );

    always #5 clk = ~clk;

    // Shadow allocator state
    logic [ORDER_W-1:0] shadow_min_order;
    logic [ORDER_W-1:0] shadow_max_order;
    bit                 shadow_free[NODES];
    logic [ORDER_W-1:0] shadow_owner_order[LEAVES];
    // Addresses currently held, so random frees can hit live blocks
    int unsigned        live_blocks[$];

    alloc_result_t pending_results[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;
    int unsigned   gap_left = 0;
    int unsigned   stall_phase = 0;

    function automatic int unsigned lower_order();
        int unsigned m;
        m = shadow_min_order;
        if (m < LEAST) m = LEAST;
        if (m > POOL) m = POOL;
        return m;
    endfunction

    function automatic int unsigned upper_order();
        int unsigned m;
        m = shadow_max_order;
        if (m < lower_order()) m = lower_order();
        if (m > POOL) m = POOL;
        return m;
    endfunction

    function automatic int unsigned node_index(int unsigned ord, int unsigned addr);
        return ((1 << (POOL - ord)) + (addr >> ord)) & (NODES - 1);
    endfunction

    function automatic void wipe_pool();
        foreach (shadow_free[i]) shadow_free[i] = 1'b0;
        foreach (shadow_owner_order[i]) shadow_owner_order[i] = '0;
        live_blocks.delete();
        shadow_free[node_index(upper_order(), 0)] = 1'b1;
    endfunction

    // Allocate: round up, search smallest free order, split downward
    function automatic alloc_result_t predict_alloc(logic [BYTES_W-1:0] nbytes);
        alloc_result_t r;
        int unsigned k, ord, lo, hi, base;
        bit found;
        r = '{block_address: '0, status: ST_NO_FIT};
        lo = lower_order();
        hi = upper_order();
        k = 0;
        while (k < 21 && (64'd1 << k) < nbytes) k++;
        if (k < lo) k = lo;
        if (k > hi) return r;
        found = 1'b0;
        base = 0;
        for (ord = k; ord <= hi && !found; ord++)
        begin
            for (int unsigned j = 0; j < (1 << (hi - ord)); j++)
            begin
                if (shadow_free[node_index(ord, j << ord)])
                begin
                    base = j << ord;
                    found = 1'b1;
                    break;
                end
            end
        end
        if (!found) return r;
        ord--;
        shadow_free[node_index(ord, base)] = 1'b0;
        while (ord > k)
        begin
            ord--;
            shadow_free[node_index(ord, base + (1 << ord))] = 1'b1;
        end
        shadow_owner_order[(base >> LEAST) & (LEAVES - 1)] = ORDER_W'(k + 1);
        live_blocks.push_back(base);
        r.block_address = ADDR_W'(base);
        r.status = ST_OK;
        return r;
    endfunction

    // Free: validate, mark free, merge with buddies upward
    function automatic alloc_result_t predict_free(logic [ADDR_W-1:0] faddr);
        alloc_result_t r;
        int unsigned a, hi, leaf, ord, buddy;
        r = '{block_address: '0, status: ST_OK};
        a = faddr;
        hi = upper_order();
        if (a >= (1 << hi))
        begin
            r.status = ST_OUT_OF_POOL;
            return r;
        end
        leaf = (a >> LEAST) & (LEAVES - 1);
        if ((a & ((1 << LEAST) - 1)) != 0 || shadow_owner_order[leaf] == 0)
        begin
            r.status = ST_NOT_ALLOC;
            return r;
        end
        ord = shadow_owner_order[leaf] - 1;
        shadow_owner_order[leaf] = '0;
        foreach (live_blocks[i])
        begin
            if (live_blocks[i] == a)
            begin
                live_blocks.delete(i);
                break;
            end
        end
        if (ord < LEAST) ord = LEAST;
        if (ord > hi) ord = hi;
        shadow_free[node_index(ord, a)] = 1'b1;
        while (ord < hi)
        begin
            buddy = a ^ (1 << ord);
            if (!shadow_free[node_index(ord, buddy)]) break;
            shadow_free[node_index(ord, buddy)] = 1'b0;
            shadow_free[node_index(ord, a)] = 1'b0;
            a &= ~(1 << ord);
            ord++;
            shadow_free[node_index(ord, a)] = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Hold the cycle counter and drop the run on timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver stalls on a repeating pattern plus random stalls, with periodic no-stall stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0)
                rsp_ch.ready <= 1'b1;          // no-stall stretch
            else
                rsp_ch.ready <= (stall_phase % 5 != 2) && ($urandom_range(3) != 0);
        end
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected response", rsp_ch.status, 0);
            end
            else
            begin
                alloc_result_t want;
                want = pending_results.pop_front();
                if (rsp_ch.block_address !== want.block_address)
                    report_mismatch("block_address", rsp_ch.block_address, want.block_address);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
            end
        end
    end

    // Send one request; random bursts and gaps in front of it.
    // Valid stays up after acceptance until a gap in the next call or drain drops it.
    task automatic send_request(logic kind, logic [BYTES_W-1:0] nbytes,
                                logic [ADDR_W-1:0] faddr);
        if (burst_left == 0)
        begin
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            burst_left = $urandom_range(1, 12);
        end
        while (gap_left > 0)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.request_bytes <= nbytes;
        req_ch.free_address <= faddr;
        do @(posedge clk); while (!req_ch.ready);
        if (kind == REQ_ALLOC)
            pending_results.push_back(predict_alloc(nbytes));
        else
            pending_results.push_back(predict_free(faddr));
    endtask

    // Advance until every response is in, then let the block settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // APB write: setup then access; also resets the shadow pool
    task automatic write_register(logic idx, logic [ORDER_W-1:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == CFG_MIN_ORDER) shadow_min_order = value;
        else shadow_max_order = value;
        wipe_pool();
    endtask

    task automatic alloc(logic [BYTES_W-1:0] n);
        send_request(REQ_ALLOC, n, ADDR_W'($urandom));
    endtask

    task automatic release_block(logic [ADDR_W-1:0] a);
        send_request(REQ_FREE, BYTES_W'($urandom), a);
    endtask

    // Field extremes, both operations and the no-fit and not-allocated statuses at reset config
    task automatic test_directed();
        alloc(0);
        alloc(1);
        alloc(17);
        alloc(BYTES_W'(1 << 15));
        alloc('1);                        // too large
        release_block(16'h0010);          // frees the alloc(1) block
        release_block(16'h0003);          // misaligned
        release_block(16'h0000);
        release_block(16'h0000);          // double free
        release_block(16'h0020);
        release_block(16'h8000);
        alloc(BYTES_W'(1 << 16));         // whole pool
        alloc(1);                         // none left
        release_block(16'h0000);
        release_block('1);
        drain();
    endtask

    // Small pool with out-of-pool frees, and clamped register extremes
    task automatic test_config_extremes();
        write_register(CFG_MAX_ORDER, 5'd6);
        alloc(2); alloc(16); alloc(20); alloc(64);
        release_block(16'h0040);          // out of pool
        release_block(16'h0010);
        write_register(CFG_MIN_ORDER, 5'd31);
        alloc(0); alloc(BYTES_W'(1 << 16)); release_block(16'h0000);
        write_register(CFG_MIN_ORDER, 5'd0);
        write_register(CFG_MAX_ORDER, 5'd0);
        alloc(1); alloc(16); release_block(16'h0000); release_block(16'h0010);
        write_register(CFG_MAX_ORDER, 5'd31);
        alloc(BYTES_W'(1 << 16)); release_block(16'h0000);
        drain();
    endtask

    // Mostly live allocate/free traffic with some junk frees
    task automatic test_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            int unsigned pick;
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                if ($urandom_range(9) == 0) alloc(BYTES_W'($urandom));
                else alloc(BYTES_W'($urandom_range(1 << $urandom_range(11))));
            end
            else if (pick < 88 && live_blocks.size() != 0)
            begin
                release_block(ADDR_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]));
            end
            else
            begin
                release_block(ADDR_W'($urandom));
            end
        end
        drain();
    endtask

    task automatic test_random_configs();
        write_register(CFG_MIN_ORDER, 5'd4);
        write_register(CFG_MAX_ORDER, 5'd16);
        test_random(400);
        write_register(CFG_MIN_ORDER, 5'd5);
        write_register(CFG_MAX_ORDER, 5'd10);
        test_random(250);
        write_register(CFG_MIN_ORDER, ORDER_W'($urandom_range(4, 8)));
        write_register(CFG_MAX_ORDER, ORDER_W'($urandom_range(8, 13)));
        test_random(250);
        write_register(CFG_MIN_ORDER, 5'd4);
        write_register(CFG_MAX_ORDER, 5'd8);
        test_random(100);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.free_address = '0;
        shadow_min_order = MIN_ORDER_RST;
        shadow_max_order = MAX_ORDER_RST;
        wipe_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random_configs();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_if.sv
hw/rtl/bba_ram.sv
hw/rtl/buddy_block_allocator_core.sv
tb/tb_buddy_block_allocator_core.sv
